@@ src/nctt_pkg.sv @@
// shared types and constants for the nearest centroid track table
package nctt_pkg;

  localparam int MAX_TRACKS_DEF = 8;

  localparam logic [2:0] REG_MATCH_RADIUS  = 3'd0;
  localparam logic [2:0] REG_ALPHA_POS     = 3'd1;
  localparam logic [2:0] REG_ALPHA_MAG     = 3'd2;
  localparam logic [2:0] REG_MAX_MISSED    = 3'd3;
  localparam logic [2:0] REG_MIN_AGE       = 3'd4;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef struct packed {
    logic        valid;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] mag;
    logic [15:0] age;
    logic [7:0]  missed;
    logic        matched;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RD_BEST,
    ST_EMA1,
    ST_EMA2,
    ST_FREE,
    ST_AGE,
    ST_OUT_RD,
    ST_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic [15:0] match_radius;
    logic [16:0] alpha_position;
    logic [16:0] alpha_magnitude;
    logic [7:0]  max_missed_frames;
    logic [7:0]  min_report_age;
  } cfg_t;

endpackage

@@ src/nctt_slot_mem.sv @@
// slot table memory with one write port and one registered read port
module nctt_slot_mem
  import nctt_pkg::*;
#(
  parameter int DEPTH = MAX_TRACKS_DEF,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  slot_t         wdata,
  input  logic [AW-1:0] raddr,
  output slot_t         rdata
);

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/nctt_ema.sv @@
// one registered exponential moving average lane
module nctt_ema
  import nctt_pkg::*;
(
  input  logic        clk,
  input  logic [16:0] alpha,
  input  logic [15:0] sample,
  input  logic [15:0] old,
  output logic [15:0] result
);

  logic [16:0] a;
  logic [32:0] p0;
  logic [32:0] p1;
  logic [33:0] acc;

  assign a   = (alpha > ONE_Q16) ? ONE_Q16 : alpha;
  assign acc = {1'b0, p0} + {1'b0, p1} + 34'd32768;

  // products registered before the sum
  always_ff @(posedge clk) begin
    p0 <= a * {1'b0, sample};
    p1 <= (ONE_Q16 - a) * {1'b0, old};
  end

  assign result = acc[31:16];

endmodule

@@ src/nearest_centroid_track_table.sv @@
// nearest centroid track table: blob matching, aging and table readout
// blob word: every slot is read once, one per cycle; a matching slot is then read again
// and updated through RD_BEST, EMA1 and EMA2, else a free slot is filled or the blob is dropped
// end of frame: every slot is aged in turn, then one result per slot through OUT_RD and OUT_WAIT
// one word at a time; the slot memory with one write and one registered read port sets the pace
// rst resets registers and runs a clearing pass that writes every slot of the table to zero
module nearest_centroid_track_table
  import nctt_pkg::*;
#(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [15:0] blob_x,
  input  logic [15:0] blob_y,
  input  logic [15:0] blob_mag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  slot_index,
  output logic        reported_active,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [15:0] smoothed_mag,
  output logic [15:0] track_age,
  output logic [7:0]  missed_count,
  output logic [3:0]  visible_count,
  output logic        last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW = $clog2(MAX_TRACKS + 1);
  localparam int READOUT = (MAX_TRACKS < 8) ? MAX_TRACKS : 8;
  localparam logic [CW-1:0] LAST_IDX = CW'(MAX_TRACKS - 1);
  localparam logic [CW-1:0] LAST_OUT = CW'(READOUT - 1);

  cfg_t cfg;
  state_t state, state_next;

  logic [CW-1:0] cnt;
  logic          clearing;
  logic          busy;
  logic          is_eof;
  logic [15:0]   bx, by, bm;
  logic [32:0]   best;
  logic          found;
  logic [AW-1:0] best_idx;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic [CW-1:0] rd_cnt;
  logic          rd_pend;
  logic [3:0]    visible;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  slot_t         wdata, rdata;
  logic [15:0]   ema_x, ema_y, ema_m;
  slot_t         hold;

  logic [16:0] dx, dy;
  logic [31:0] dx2, dy2;
  logic [32:0] d2;
  logic [7:0]  miss_inc;
  logic        rep;

  nctt_slot_mem #(.DEPTH(MAX_TRACKS), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // old values come straight from the memory while the best slot is on rdata
  nctt_ema u_ema_x (.clk(clk), .alpha(cfg.alpha_position), .sample(bx), .old(rdata.x),
                    .result(ema_x));
  nctt_ema u_ema_y (.clk(clk), .alpha(cfg.alpha_position), .sample(by), .old(rdata.y),
                    .result(ema_y));
  nctt_ema u_ema_m (.clk(clk), .alpha(cfg.alpha_magnitude), .sample(bm), .old(rdata.mag),
                    .result(ema_m));

  assign in_ready = (state == ST_IDLE) && !clearing && !out_valid;

  // distance of the slot arriving from memory
  assign dx  = {1'b0, bx} - {1'b0, rdata.x};
  assign dy  = {1'b0, by} - {1'b0, rdata.y};
  assign dx2 = (dx[16] ? 16'(-dx) : dx[15:0]) * (dx[16] ? 16'(-dx) : dx[15:0]);
  assign dy2 = (dy[16] ? 16'(-dy) : dy[15:0]) * (dy[16] ? 16'(-dy) : dy[15:0]);
  assign d2  = {1'b0, dx2} + {1'b0, dy2};
  assign miss_inc = (rdata.missed == 8'hff) ? 8'hff : rdata.missed + 8'd1;
  assign rep = rdata.valid && (rdata.age >= {8'd0, cfg.min_report_age});
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_radius      <= 16'd6554;
      cfg.alpha_position    <= 17'd32768;
      cfg.alpha_magnitude   <= 17'd19661;
      cfg.max_missed_frames <= 8'd5;
      cfg.min_report_age    <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH_RADIUS: cfg.match_radius      <= cfg_data[15:0];
        REG_ALPHA_POS:    cfg.alpha_position    <= cfg_data;
        REG_ALPHA_MAG:    cfg.alpha_magnitude   <= cfg_data;
        REG_MAX_MISSED:   cfg.max_missed_frames <= cfg_data[7:0];
        REG_MIN_AGE:      cfg.min_report_age    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid && in_ready) state_next = opcode ? ST_AGE : ST_SCAN;
      ST_SCAN:     if (rd_pend && rd_cnt == LAST_IDX) state_next = ST_DECIDE;
      ST_DECIDE:   state_next = found ? ST_RD_BEST : (free_found ? ST_FREE : ST_IDLE);
      ST_RD_BEST:  state_next = ST_EMA1;
      ST_EMA1:     state_next = ST_EMA2;
      ST_EMA2:     state_next = ST_IDLE;
      ST_FREE:     state_next = ST_IDLE;
      ST_AGE:      if (rd_pend && rd_cnt == LAST_IDX) state_next = ST_OUT_RD;
      ST_OUT_RD:   state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: if (out_valid && out_ready)
                     state_next = (cnt == LAST_OUT) ? ST_IDLE : ST_OUT_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory address and write control
  always_comb begin
    we    = 1'b0;
    waddr = rd_cnt[AW-1:0];
    wdata = rdata;
    raddr = cnt[AW-1:0];
    if (clearing) begin
      we    = 1'b1;
      waddr = cnt[AW-1:0];
      wdata = '0;
    end else begin
      case (state)
        ST_RD_BEST: raddr = best_idx;
        ST_EMA2: begin
          we    = 1'b1;
          waddr = best_idx;
          wdata = hold;
          wdata.x = ema_x;
          wdata.y = ema_y;
          wdata.mag = ema_m;
          wdata.missed = 8'd0;
          wdata.age = (hold.age == 16'hffff) ? hold.age : hold.age + 16'd1;
          wdata.matched = 1'b1;
        end
        ST_FREE: begin
          we    = 1'b1;
          waddr = free_idx;
          wdata = '{valid: 1'b1, x: bx, y: by, mag: bm, age: 16'd1, missed: 8'd0,
                    matched: 1'b1};
        end
        ST_AGE: if (rd_pend) begin
          we    = 1'b1;
          wdata = rdata;
          wdata.matched = 1'b0;
          if (rdata.valid && !rdata.matched) begin
            wdata.missed = miss_inc;
            if (miss_inc >= cfg.max_missed_frames) wdata = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      clearing  <= 1'b1;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      is_eof    <= 1'b0;
    end else if (clearing) begin
      if (cnt == LAST_IDX) begin
        clearing <= 1'b0;
        cnt      <= '0;
      end else begin
        cnt <= cnt + CW'(1);
      end
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in_valid && in_ready) begin
          bx <= blob_x; by <= blob_y; bm <= blob_mag;
          is_eof     <= opcode;
          cnt        <= '0;
          rd_pend    <= 1'b0;
          best       <= {1'b0, cfg.match_radius} * {1'b0, cfg.match_radius};
          found      <= 1'b0;
          free_found <= 1'b0;
          visible    <= '0;
        end
        ST_SCAN, ST_AGE: begin
          if (state_next == ST_OUT_RD) cnt <= '0;
          else if (cnt != CW'(MAX_TRACKS)) cnt <= cnt + CW'(1);
          rd_pend <= (cnt != CW'(MAX_TRACKS));
          rd_cnt  <= cnt;
          if (rd_pend && state == ST_SCAN) begin
            if (rdata.valid && d2 < best) begin
              best <= d2; found <= 1'b1; best_idx <= rd_cnt[AW-1:0];
            end
            if (!rdata.valid && !free_found) begin
              free_found <= 1'b1; free_idx <= rd_cnt[AW-1:0];
            end
          end
        end
        ST_EMA1: ;
        ST_RD_BEST: ;
        ST_OUT_WAIT: if (out_valid && out_ready) cnt <= cnt + CW'(1);
        default: ;
      endcase
      if (state == ST_OUT_WAIT && !out_valid && !(is_eof && busy)) begin
        out_valid       <= 1'b1;
        slot_index      <= 3'(cnt);
        reported_active <= rep;
        pos_x           <= rdata.x;
        pos_y           <= rdata.y;
        smoothed_mag    <= rdata.mag;
        track_age       <= rdata.age;
        missed_count    <= rdata.missed;
        visible_count   <= visible + {3'd0, rep};
        visible         <= visible + {3'd0, rep};
        last            <= (cnt == LAST_OUT);
      end
    end
  end

  // best slot held for the write back
  always_ff @(posedge clk) begin
    if (state == ST_EMA1) hold <= rdata;
  end

endmodule

@@ dv/tb_nearest_centroid_track_table.sv @@
// testbench for the nearest centroid track table: predicts matching, aging and readout
module tb_nearest_centroid_track_table;
  import nctt_pkg::*;

  localparam int NSLOT = 8;

  typedef struct packed {
    logic        op;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] mag;
  } blob_word_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic        act;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] mag;
    logic [15:0] age;
    logic [7:0]  missed;
    logic [3:0]  vis;
    logic        lst;
  } slot_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = 1'b0;
  logic [15:0] blob_x = '0, blob_y = '0, blob_mag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] slot_index;
  logic reported_active;
  logic [15:0] pos_x, pos_y, smoothed_mag, track_age;
  logic [7:0] missed_count;
  logic [3:0] visible_count;
  logic last;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  nearest_centroid_track_table dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the table and registers
  slot_t trk [NSLOT];
  logic [15:0] radius;
  logic [16:0] a_pos, a_mag;
  logic [7:0] miss_lim, min_age;

  blob_word_t pending_words[$];
  slot_report_t expected_reports[$];
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;
  bit accepted_last = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
    $display("mismatch %s: got %0h expected %0h", what, got, exp_v);
    errors++;
  endtask

  function automatic logic [15:0] smooth(input logic [16:0] a, input logic [15:0] s, o);
    logic [63:0] w, acc;
    w = (a > ONE_Q16) ? 64'(ONE_Q16) : 64'(a);
    acc = w * s + (64'(ONE_Q16) - w) * o + 64'd32768;
    return acc[31:16];
  endfunction

  task automatic predict_word(input blob_word_t w);
    logic [63:0] best, d2;
    longint dx, dy;
    int bi;
    int vis;
    slot_report_t r;
    if (!w.op) begin
      best = 64'(radius) * radius;
      bi = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (trk[i].valid) begin
          dx = longint'(w.x) - longint'(trk[i].x);
          dy = longint'(w.y) - longint'(trk[i].y);
          d2 = dx * dx + dy * dy;
          if (d2 < best) begin
            best = d2;
            bi = i;
          end
        end
      end
      if (bi >= 0) begin
        trk[bi].x = smooth(a_pos, w.x, trk[bi].x);
        trk[bi].y = smooth(a_pos, w.y, trk[bi].y);
        trk[bi].mag = smooth(a_mag, w.mag, trk[bi].mag);
        trk[bi].missed = '0;
        if (trk[bi].age != 16'hFFFF) trk[bi].age++;
        trk[bi].matched = 1'b1;
      end else begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!trk[i].valid && bi < 0) begin
            trk[i] = '{1'b1, w.x, w.y, w.mag, 16'd1, 8'd0, 1'b1};
            bi = i;
          end
        end
      end
    end else begin
      vis = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (trk[i].valid && !trk[i].matched) begin
          if (trk[i].missed != 8'hFF) trk[i].missed++;
          if (trk[i].missed >= miss_lim) trk[i] = '0;
        end
        trk[i].matched = 1'b0;
      end
      for (int i = 0; i < NSLOT; i++) begin
        r.act = trk[i].valid && (trk[i].age >= 16'(min_age));
        if (r.act) vis++;
        r.idx = 3'(i);
        r.x = trk[i].x;
        r.y = trk[i].y;
        r.mag = trk[i].mag;
        r.age = trk[i].age;
        r.missed = trk[i].missed;
        r.vis = 4'(vis);
        r.lst = (i == NSLOT - 1);
        expected_reports.push_back(r);
      end
    end
  endtask

  // driver: bursts with gaps; valid stays up across back-to-back words
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        // accepted at previous posedge
      end
      if (!in_valid || accepted_last) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          opcode <= pending_words[0].op;
          blob_x <= pending_words[0].x;
          blob_y <= pending_words[0].y;
          blob_mag <= pending_words[0].mag;
          void'(pending_words.pop_front());
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
          end else burst_left--;
        end else in_valid <= 1'b0;
      end
      stall_phase++;
      out_ready <= (stall_phase % 23 < 9) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    slot_report_t e;
    accepted_last <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) predict_word('{opcode, blob_x, blob_y, blob_mag});
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected report", slot_index, 0);
      end else begin
        e = expected_reports.pop_front();
        if (slot_index !== e.idx) report_mismatch("slot_index", slot_index, e.idx);
        if (reported_active !== e.act) report_mismatch("reported_active", reported_active, e.act);
        if (pos_x !== e.x) report_mismatch("pos_x", pos_x, e.x);
        if (pos_y !== e.y) report_mismatch("pos_y", pos_y, e.y);
        if (smoothed_mag !== e.mag) report_mismatch("smoothed_mag", smoothed_mag, e.mag);
        if (track_age !== e.age) report_mismatch("track_age", track_age, e.age);
        if (missed_count !== e.missed) report_mismatch("missed_count", missed_count, e.missed);
        if (visible_count !== e.vis) report_mismatch("visible_count", visible_count, e.vis);
        if (last !== e.lst) report_mismatch("last", last, e.lst);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MATCH_RADIUS: radius = val[15:0];
      REG_ALPHA_POS:    a_pos = val;
      REG_ALPHA_MAG:    a_mag = val;
      REG_MAX_MISSED:   miss_lim = val[7:0];
      REG_MIN_AGE:      min_age = val[7:0];
      default: ;
    endcase
  endtask

  // wait for everything to drain, plus slack for a blob still being matched
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_word(input logic op, input logic [15:0] x, y, m);
    pending_words.push_back('{op, x, y, m});
  endtask

  // frames of blobs that mostly follow existing tracks with small jitter
  task automatic random_phase(input int n);
    logic [15:0] cx [4];
    for (int k = 0; k < 4; k++) cx[k] = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      int k;
      k = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0, 1: add_word(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
        2: add_word(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
        default: add_word(1'b0, cx[k] + 16'($urandom_range(0, 2000)),
                          cx[k] ^ 16'h5a5a + 16'($urandom_range(0, 2000)), 16'($urandom));
      endcase
    end
    add_word(1'b1, '0, '0, '0);
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) trk[i] = '0;
    radius = 16'd6554;
    a_pos = 17'd32768;
    a_mag = 17'd19661;
    miss_lim = 8'd5;
    min_age = 8'd3;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2 * NSLOT) @(posedge clk);
    // directed: reset settings, extremes, ties, overflow of the table
    add_word(1'b1, '0, '0, '0);
    add_word(1'b0, 16'h0000, 16'h0000, 16'h0000);
    add_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_word(1'b0, 16'h0010, 16'h0010, 16'h1234);
    add_word(1'b0, 16'h0008, 16'h0008, 16'h8000);
    add_word(1'b1, '0, '0, '0);
    for (int i = 0; i < 9; i++) add_word(1'b0, 16'(i * 16'h1c00), 16'h8000, 16'(i));
    add_word(1'b0, 16'h8000, 16'h8000, 16'hFFFF);
    add_word(1'b1, '0, '0, '0);
    add_word(1'b1, '0, '0, '0);
    drain();
    // extremes of the registers
    write_reg(REG_MATCH_RADIUS, 17'd65535);
    write_reg(REG_ALPHA_POS, 17'd65536);
    write_reg(REG_ALPHA_MAG, 17'd0);
    write_reg(REG_MAX_MISSED, 17'd255);
    write_reg(REG_MIN_AGE, 17'd0);
    random_phase(40);
    drain();
    write_reg(REG_MATCH_RADIUS, 17'd0);
    write_reg(REG_ALPHA_POS, 17'h1FFFF);
    write_reg(REG_ALPHA_MAG, 17'd65536);
    write_reg(REG_MAX_MISSED, 17'd1);
    write_reg(REG_MIN_AGE, 17'd255);
    random_phase(30);
    drain();
    write_reg(REG_MATCH_RADIUS, 17'($urandom_range(1000, 20000)));
    write_reg(REG_ALPHA_POS, 17'($urandom_range(0, 65536)));
    write_reg(REG_ALPHA_MAG, 17'($urandom_range(0, 131071)));
    write_reg(REG_MAX_MISSED, 17'($urandom_range(0, 6)));
    write_reg(REG_MIN_AGE, 17'($urandom_range(0, 4)));
    random_phase(70);
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
